/* rtl/dfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the delimited field selector.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // Byte emitted at the end of every line
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // Configuration port geometry: 64-bit registers at 8-byte strides
  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // Register indexes
  localparam logic [2:0] REG_DELIM_SET     = 3'd0;
  localparam logic [2:0] REG_DELIM_COUNT   = 3'd1;
  localparam logic [2:0] REG_FIELD_MASK    = 3'd2;
  localparam logic [2:0] REG_OUT_SEP_BYTES = 3'd3;
  localparam logic [2:0] REG_OUT_SEP_LEN   = 3'd4;

  // Reset values of the registers
  localparam logic [31:0] DELIM_SET_RST     = 32'd44;
  localparam logic [2:0]  DELIM_COUNT_RST   = 3'd1;
  localparam logic [63:0] FIELD_MASK_RST    = 64'd0;
  localparam logic [31:0] OUT_SEP_BYTES_RST = 32'd44;
  localparam logic [2:0]  OUT_SEP_LEN_RST   = 3'd1;

  // Depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // One job: what a single input item asks the back end to emit, in order:
  // sep_cnt separator bytes, the data byte if data_en, a newline if nl.
  typedef struct packed {
    logic [2:0] sep_cnt;
    logic       data_en;
    logic [7:0] data;
    logic       nl;
  } dfs_job_t;

endpackage

/* rtl/dfs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_in_if / dfs_out_if
// Valid/ready channels for line bytes in and selected bytes out.
// ----------------------------------------------------------------------------
interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source  (output valid, in_byte, line_end, input ready);
  modport sink    (input valid, in_byte, line_end, output ready);
  modport monitor (input valid, ready, in_byte, line_end);
endinterface

interface dfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source  (output valid, out_byte, run_last, input ready);
  modport sink    (input valid, out_byte, run_last, output ready);
  modport monitor (input valid, ready, out_byte, run_last);
endinterface

/* rtl/dfs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_front
// Takes line bytes, tracks fields, makes a job per selected byte or line end.
// ----------------------------------------------------------------------------
module dfs_front #(
  parameter int unsigned MAX_FIELDS  = 64,
  parameter int unsigned DELIM_SLOTS = 4,
  parameter int unsigned SEP_SLOTS   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dfs_in_if.sink            in_if,
  input  logic [31:0]       delim_set_i,
  input  logic [2:0]        delim_count_i,
  input  logic [63:0]       field_mask_i,
  input  logic [2:0]        out_sep_len_i,
  input  logic              q_full_i,
  output logic              push_o,
  output dfs_pkg::dfs_job_t job_o
);
  import dfs_pkg::*;

  localparam int unsigned DELIM_LIM = (DELIM_SLOTS < 4) ? DELIM_SLOTS : 4;
  localparam int unsigned SEP_LIM   = (SEP_SLOTS < 4) ? SEP_SLOTS : 4;
  localparam int unsigned FNUM_W    = $clog2(MAX_FIELDS + 2);
  localparam logic [FNUM_W-1:0] FNUM_SAT = FNUM_W'(MAX_FIELDS + 1);

  logic              inside_q, inside_d;
  logic [FNUM_W-1:0] fnum_q, fnum_d;
  logic              emitted_q, emitted_d;

  logic [DELIM_LIM-1:0] hit;
  logic                 is_delim;
  logic                 accept;
  logic                 start;
  logic [FNUM_W-1:0]    fnum_new;
  logic [6:0]           fnum7;
  logic [5:0]           mask_idx;
  logic                 sel;
  logic [2:0]           sep_len;

  // Compare against every active delimiter slot
  for (genvar k = 0; k < DELIM_LIM; k++) begin : g_delim
    assign hit[k] = (delim_count_i > 3'(k)) && (delim_set_i[8*k +: 8] == in_if.in_byte);
  end
  assign is_delim = |hit;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;

  // Clamp the separator length
  assign sep_len = (out_sep_len_i > 3'(SEP_LIM)) ? 3'(SEP_LIM) : out_sep_len_i;

  // Advance the field number on the first byte of a field, saturating
  assign start    = !is_delim && !inside_q;
  assign fnum_new = (start && (fnum_q < FNUM_SAT)) ? fnum_q + 1'b1 : fnum_q;
  assign fnum7    = 7'(fnum_new);
  assign mask_idx = 6'(fnum7 - 7'd1);
  assign sel      = !is_delim && (fnum7 != 7'd0) && (fnum7 <= 7'(MAX_FIELDS))
                    && field_mask_i[mask_idx];

  // Build the job and the next state
  always_comb begin
    job_o.sep_cnt = (start && sel && emitted_q) ? sep_len : 3'd0;
    job_o.data_en = sel;
    job_o.data    = in_if.in_byte;
    job_o.nl      = in_if.line_end;
    push_o        = accept && (sel || in_if.line_end);

    inside_d  = !is_delim;
    fnum_d    = fnum_new;
    emitted_d = emitted_q || (start && sel);
    if (in_if.line_end) begin
      inside_d  = 1'b0;
      fnum_d    = '0;
      emitted_d = 1'b0;
    end
  end

  // Update line state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      fnum_q    <= '0;
      emitted_q <= 1'b0;
    end else if (accept) begin
      inside_q  <= inside_d;
      fnum_q    <= fnum_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

/* rtl/dfs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_queue
// Small job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dfs_pkg::dfs_job_t job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output dfs_pkg::dfs_job_t head_o
);
  import dfs_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  dfs_job_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/dfs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_back
// Expands the queue head job into output bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dfs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  dfs_pkg::dfs_job_t head_i,
  input  logic [31:0]       out_sep_bytes_i,
  output logic              pop_o,
  dfs_out_if.source         out_if
);
  import dfs_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [2:0] phase_q, phase_d;

  logic [2:0] total;
  logic       is_last;
  logic       load;
  logic [7:0] byte_d;

  // Total bytes of the head job and the byte of the current phase
  assign total   = head_i.sep_cnt + 3'(head_i.data_en) + 3'(head_i.nl);
  assign is_last = (phase_q == total - 3'd1);
  assign load    = !empty_i && (!valid_q || out_if.ready);
  assign pop_o   = load && is_last;
  assign phase_d = is_last ? 3'd0 : phase_q + 3'd1;

  always_comb begin
    if (phase_q < head_i.sep_cnt) begin
      byte_d = out_sep_bytes_i[8*phase_q[1:0] +: 8];
    end else if (head_i.data_en && (phase_q == head_i.sep_cnt)) begin
      byte_d = head_i.data;
    end else begin
      byte_d = NEWLINE_BYTE;
    end
  end

  // Output register: load a new byte or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 3'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      phase_q <= phase_d;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= is_last;
    end
  end

  assign out_if.valid    = valid_q;
  assign out_if.out_byte = byte_q;
  assign out_if.run_last = last_q;

endmodule

/* rtl/delimited_field_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_selector
// Passes on the selected delimiter-separated fields of a byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_if     in   valid/ready        in_byte[7:0], line_end
//  out_if    out  valid/ready        out_byte[7:0], run_last
//  apb       in   psel/penable/...   64-bit registers at paddr = 8*index
//
//  An item is accepted whenever the four-entry job queue has room; its job
//  leaves the back end at one output byte per unstalled cycle (up to six bytes).
//  Sustained input rate is one item per cycle while each item yields at most
//  one output byte; the back end's single output register sets the limit.
//  Asynchronous active-low reset clears line state, queue and output valid.
//  A stalled output holds the output register; input stalls only on a full queue.
// ----------------------------------------------------------------------------
module delimited_field_selector #(
  parameter int unsigned MAX_FIELDS  = 64,
  parameter int unsigned DELIM_SLOTS = 4,
  parameter int unsigned SEP_SLOTS   = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dfs_in_if.sink                     in_if,
  dfs_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfs_pkg::APB_AW-1:0] paddr,
  input  logic [dfs_pkg::APB_DW-1:0] pwdata,
  output logic [dfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import dfs_pkg::*;

  logic [31:0] delim_set_q;
  logic [2:0]  delim_count_q;
  logic [63:0] field_mask_q;
  logic [31:0] out_sep_bytes_q;
  logic [2:0]  out_sep_len_q;

  logic       wr_en;
  logic [2:0] reg_idx;

  logic     push, pop, q_full, q_empty;
  dfs_job_t job, head;

  // Configuration registers
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_set_q     <= DELIM_SET_RST;
      delim_count_q   <= DELIM_COUNT_RST;
      field_mask_q    <= FIELD_MASK_RST;
      out_sep_bytes_q <= OUT_SEP_BYTES_RST;
      out_sep_len_q   <= OUT_SEP_LEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DELIM_SET:     delim_set_q     <= pwdata[31:0];
        REG_DELIM_COUNT:   delim_count_q   <= pwdata[2:0];
        REG_FIELD_MASK:    field_mask_q    <= pwdata;
        REG_OUT_SEP_BYTES: out_sep_bytes_q <= pwdata[31:0];
        REG_OUT_SEP_LEN:   out_sep_len_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_DELIM_SET:     prdata = {32'd0, delim_set_q};
      REG_DELIM_COUNT:   prdata = {61'd0, delim_count_q};
      REG_FIELD_MASK:    prdata = field_mask_q;
      REG_OUT_SEP_BYTES: prdata = {32'd0, out_sep_bytes_q};
      REG_OUT_SEP_LEN:   prdata = {61'd0, out_sep_len_q};
      default:           prdata = '0;
    endcase
  end

  dfs_front #(
    .MAX_FIELDS  (MAX_FIELDS),
    .DELIM_SLOTS (DELIM_SLOTS),
    .SEP_SLOTS   (SEP_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .delim_set_i   (delim_set_q),
    .delim_count_i (delim_count_q),
    .field_mask_i  (field_mask_q),
    .out_sep_len_i (out_sep_len_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (job)
  );

  dfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  dfs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .head_i          (head),
    .out_sep_bytes_i (out_sep_bytes_q),
    .pop_o           (pop),
    .out_if          (out_if)
  );

endmodule

/* rtl/dfs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the delimited field selector, bound to the top level.
// ----------------------------------------------------------------------------
module dfs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  dfs_in_if.sink                    in_if,
  dfs_out_if.source                 out_if,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [dfs_pkg::APB_AW-1:0] paddr,
  input logic [dfs_pkg::APB_DW-1:0] pwdata,
  input logic [dfs_pkg::APB_DW-1:0] prdata,
  input logic                       pready
);
  import dfs_pkg::*;

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=>
      out_if.valid && $stable(out_if.out_byte) && $stable(out_if.run_last))
    else $error("output item changed while stalled");

  // A full queue implies the output register is occupied
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled while output side idle");

  // Field mask reads back what was just written
  a_mask_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[5:3] == REG_FIELD_MASK) |=>
      (paddr[5:3] != REG_FIELD_MASK) || (prdata == $past(pwdata)))
    else $error("field mask read back mismatch");

  // No output item right after reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_if.valid)
    else $error("output valid right after reset");

endmodule

bind delimited_field_selector dfs_checker u_dfs_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_if   (in_if),
  .out_if  (out_if),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready)
);

/* sim/delimited_field_selector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_selector_tb
// Self-checking bench for the field selector. Text lines go in one byte per
// item under random bursts and gaps. Register settings change between phases
// through the configuration port. Every emitted byte is compared in order with
// the bytes that an in-bench line model predicts.
// ----------------------------------------------------------------------------
module delimited_field_selector_tb;
  import dfs_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RST_CYCLES   = 12;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned DRAIN_GUARD  = 20000;
  localparam int unsigned FIELD_LIMIT  = 64;
  localparam int unsigned SLOT_LIMIT   = 4;
  localparam int unsigned PHASE_ITEMS  = 10;
  localparam int unsigned RAND_PHASES  = 5;
  localparam logic [2:0]  REG_UNMAPPED = 3'd6;
  localparam logic [7:0]  COMMA        = 8'h2C;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
  } sel_byte_t;

  logic clk_i;
  logic rst_ni;

  dfs_in_if  in_ch ();
  dfs_out_if out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  delimited_field_selector i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers
  logic [31:0] cfg_delim_set;
  logic [2:0]  cfg_delim_cnt;
  logic [63:0] cfg_mask;
  logic [31:0] cfg_sep_bytes;
  logic [2:0]  cfg_sep_len;

  // Line state of the model
  logic        in_field;
  int unsigned field_num;
  logic        sel_seen;

  // Bytes the block still owes, oldest first
  sel_byte_t   selected_q[$];

  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned bytes_checked;
  int unsigned lines_sent;
  int unsigned burst_left;
  bit          steady;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(64'd4_000_000);
    $display("%0t: run limit reached", $time);
    $display("delimited_field_selector: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line model
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_slots(logic [2:0] n);
    int unsigned r;
    r = n;
    if (r > SLOT_LIMIT) r = SLOT_LIMIT;
    return r;
  endfunction

  function automatic bit is_delim(logic [7:0] b);
    for (int k = 0; k < clamp_slots(cfg_delim_cnt); k++) begin
      if (cfg_delim_set[8*k +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit field_on(int unsigned num);
    if (num < 1 || num > FIELD_LIMIT) return 1'b0;
    return cfg_mask[num-1];
  endfunction

  // Advance the line state by one byte and queue the bytes it must produce
  function automatic void select_byte(logic [7:0] b, logic le);
    sel_byte_t res[$];
    if (is_delim(b)) begin
      in_field = 1'b0;
    end else begin
      if (!in_field) begin
        if (field_num < FIELD_LIMIT + 1) field_num++;
        in_field = 1'b1;
        if (field_on(field_num)) begin
          if (sel_seen) begin
            for (int k = 0; k < clamp_slots(cfg_sep_len); k++) begin
              res.push_back('{cfg_sep_bytes[8*k +: 8], 1'b0});
            end
          end
          sel_seen = 1'b1;
        end
      end
      if (field_on(field_num)) res.push_back('{b, 1'b0});
    end
    if (le) begin
      res.push_back('{NEWLINE_BYTE, 1'b0});
      in_field  = 1'b0;
      field_num = 0;
      sel_seen  = 1'b0;
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) selected_q.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: check each accepted byte, stall on a rotating pattern
  // ---------------------------------------------------------------------------
  logic [31:0] stall_pat = '1;
  int unsigned stall_age = 0;

  always @(posedge clk_i) begin : rx_check
    sel_byte_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (selected_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual 0x%02h run_last %0b",
                 $time, out_ch.out_byte, out_ch.run_last);
        err_cnt++;
      end else begin
        want = selected_q.pop_front();
        bytes_checked++;
        if (want.out_byte !== out_ch.out_byte) begin
          $display("%0t: out_byte: expected 0x%02h, actual 0x%02h",
                   $time, want.out_byte, out_ch.out_byte);
          err_cnt++;
        end
        if (want.run_last !== out_ch.run_last) begin
          $display("%0t: run_last: expected %0b, actual %0b",
                   $time, want.run_last, out_ch.run_last);
          err_cnt++;
        end
      end
    end
    // pick a new stall pattern now and then
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom;
        2:       stall_pat = $urandom | $urandom;
        default: stall_pat = 32'h0000_FFFF;
      endcase
      stall_age = $urandom_range(16, 96);
    end else begin
      stall_age--;
    end
    out_ch.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[31:1]};
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Send one item; gaps fall between random bursts unless the phase is steady
  task automatic push_char(input logic [7:0] b, input logic le);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.line_end <= le;
    do @(posedge clk_i); while (!in_ch.ready);
    select_byte(b, le);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // Hold off input until every owed byte has arrived, then let the block settle
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (selected_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    while (selected_q.size() != 0) begin
      $display("%0t: missing byte: expected 0x%02h run_last %0b, actual none",
               $time, selected_q[0].out_byte, selected_q[0].run_last);
      err_cnt++;
      void'(selected_q.pop_front());
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access cycle; the register takes the value at the access edge.
  // End on an idle cycle so the next transfer starts at a later edge.
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DELIM_SET:     cfg_delim_set = val[31:0];
      REG_DELIM_COUNT:   cfg_delim_cnt = val[2:0];
      REG_FIELD_MASK:    cfg_mask      = val;
      REG_OUT_SEP_BYTES: cfg_sep_bytes = val[31:0];
      REG_OUT_SEP_LEN:   cfg_sep_len   = val[2:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic [31:0] dset, input logic [2:0] dcnt,
                         input logic [63:0] mask, input logic [31:0] sep,
                         input logic [2:0] slen);
    reg_write(REG_DELIM_SET, 64'(dset));
    reg_write(REG_DELIM_COUNT, 64'(dcnt));
    reg_write(REG_FIELD_MASK, mask);
    reg_write(REG_OUT_SEP_BYTES, 64'(sep));
    reg_write(REG_OUT_SEP_LEN, 64'(slen));
  endtask

  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_delim(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_delim();
    int unsigned k;
    k = $urandom_range(0, clamp_slots(cfg_delim_cnt) - 1);
    return cfg_delim_set[8*k +: 8];
  endfunction

  // Well-formed line: optional leading delimiters, fields, delimiter runs
  task automatic send_line(input int unsigned n_fields, input int unsigned max_len,
                           input int unsigned max_run);
    logic [7:0] line[$];
    bit         has_delim;
    has_delim = clamp_slots(cfg_delim_cnt) > 0;
    if (has_delim && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, max_run)) line.push_back(pick_delim());
    end
    for (int f = 0; f < n_fields; f++) begin
      repeat ($urandom_range(1, max_len)) line.push_back(pick_text());
      if (has_delim && (f + 1 < n_fields || $urandom_range(0, 2) == 0)) begin
        repeat ($urandom_range(1, max_run)) line.push_back(pick_delim());
      end
    end
    foreach (line[i]) push_char(line[i], i == line.size() - 1);
    lines_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings select nothing: only the newline comes out
  task automatic test_reset_defaults();
    push_char("a", 1'b0);
    push_char(COMMA, 1'b0);
    push_char("b", 1'b1);
    lines_sent++;
  endtask

  // Fields 1 and 3 with leading delimiters and a delimiter run
  task automatic test_field_select();
    wait_drained();
    reg_write(REG_FIELD_MASK, 64'h5);
    push_char(COMMA, 1'b0);
    push_char(COMMA, 1'b0);
    push_char("a", 1'b0);
    push_char("b", 1'b0);
    push_char(COMMA, 1'b0);
    push_char(COMMA, 1'b0);
    push_char("c", 1'b0);
    push_char(COMMA, 1'b0);
    push_char("d", 1'b1);
    lines_sent++;
  endtask

  // Full delimiter set holding 0x00 and 0xFF, oversized count, then no delimiters
  task automatic test_delim_extremes();
    wait_drained();
    set_all({8'h00, 8'hFF, 8'h3B, 8'h20}, 3'd4, '1, 32'h4433_2211, 3'd4);
    push_char(8'h00, 1'b0);
    push_char("x", 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h20, 1'b0);
    push_char("y", 1'b0);
    push_char(8'h3B, 1'b0);
    push_char("z", 1'b1);
    wait_drained();
    reg_write(REG_DELIM_COUNT, 64'd7);
    push_char(8'h3B, 1'b0);
    push_char("v", 1'b1);
    wait_drained();
    // no delimiters: a zero byte is plain text and the line is one field
    reg_write(REG_DELIM_COUNT, 64'd0);
    push_char(8'h00, 1'b0);
    push_char(8'h20, 1'b1);
    lines_sent += 3;
  endtask

  // Switch the mask between the fields of one line
  task automatic test_mask_midline();
    wait_drained();
    set_all(32'(COMMA), 3'd1, 64'h1, 32'(COMMA), 3'd1);
    push_char("a", 1'b0);
    push_char(COMMA, 1'b0);
    wait_drained();
    reg_write(REG_FIELD_MASK, 64'h2);
    push_char("b", 1'b1);
    lines_sent++;
  endtask

  // A write to an unused address must leave every register alone
  task automatic test_unmapped_register();
    wait_drained();
    reg_write(REG_UNMAPPED, '1);
    push_char("q", 1'b1);
    lines_sent++;
  endtask

  // One long line of single-byte fields runs the field counter past its top
  task automatic test_field_overflow();
    wait_drained();
    set_all(32'($urandom), 3'd1, {2'b10, 30'($urandom), 30'($urandom), 2'b01},
            $urandom, 3'd2);
    send_line(67, 1, 1);
  endtask

  // Random phases: well-formed lines with some noise, settings per phase
  task automatic test_random_traffic();
    int unsigned start;
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      steady = (p == 2);
      case (p)
        0: set_all('1, 3'd1, '1, '0, 3'd7);
        1: set_all('0, 3'd2, '0, '1, 3'd0);
        default: begin
          set_all($urandom, 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                              : {$urandom, $urandom} & {$urandom, $urandom},
                  $urandom, 3'($urandom_range(0, 7)));
        end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          send_line($urandom_range(1, 6), 3, 2);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            push_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
          end
        end
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.line_end = 1'b0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_ni         = 1'b0;

    cfg_delim_set = DELIM_SET_RST;
    cfg_delim_cnt = DELIM_COUNT_RST;
    cfg_mask      = FIELD_MASK_RST;
    cfg_sep_bytes = OUT_SEP_BYTES_RST;
    cfg_sep_len   = OUT_SEP_LEN_RST;
    in_field      = 1'b0;
    field_num     = 0;
    sel_seen      = 1'b0;
    err_cnt       = 0;
    items_sent    = 0;
    bytes_checked = 0;
    lines_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_select();
    test_delim_extremes();
    test_mask_midline();
    test_unmapped_register();
    test_field_overflow();
    test_random_traffic();
    wait_drained();

    $display("Sent %0d items over %0d lines; checked %0d output bytes.",
             items_sent, lines_sent, bytes_checked);
    $display("Settings ranged from empty to full delimiter sets and masks, "
             , "zero to oversized separators, and a line past field 64.");
    if (err_cnt == 0) begin
      $display("delimited_field_selector: match");
    end else begin
      $display("delimited_field_selector: mismatch");
    end
    $finish;
  end

endmodule
